// ===== hw/rtl/stt_pkg.sv =====
// Shared types and codes for the source text tokenizer.
// Holds the token record, the scanner-to-queue push record and the result codes.
// No dependencies.
`default_nettype none

package stt_pkg;

  localparam logic [3:0] KIND_IDENT     = 4'd0;
  localparam logic [3:0] KIND_INT       = 4'd1;
  localparam logic [3:0] KIND_DOUBLE    = 4'd2;
  localparam logic [3:0] KIND_STRING    = 4'd3;
  localparam logic [3:0] KIND_SINGLE_OP = 4'd4;
  localparam logic [3:0] KIND_PLUS_PLUS = 4'd5;
  localparam logic [3:0] KIND_PLUS_EQ   = 4'd6;
  localparam logic [3:0] KIND_EQ_EQ     = 4'd7;
  localparam logic [3:0] KIND_END       = 4'd8;
  localparam logic [3:0] KIND_ERROR     = 4'd9;

  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN_BYTE = 2'd1;
  localparam logic [1:0] ERR_BAD_EXPONENT = 2'd2;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  opch;
    logic [31:0] start;
    logic [15:0] length;
    logic [1:0]  err;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stt_scanner.sv =====
// Front part of the tokenizer: accepts source bytes and runs the lexer state machine.
// Produces up to two tokens per beat as a push record for the result queue.
// Depends on stt_pkg.
`default_nettype none

module stt_scanner #(
  parameter int NEST_BITS     = 8,
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_char_byte,
  input  wire logic         in_end_of_input,
  input  wire logic         space_ok,
  output stt_pkg::push_t    push
);
  import stt_pkg::*;

  localparam logic [7:0] CH_LO_B     = 8'h62;
  localparam logic [7:0] CH_UP_B     = 8'h42;
  localparam logic [7:0] CH_LO_E     = 8'h65;
  localparam logic [7:0] CH_UP_E     = 8'h45;
  localparam logic [7:0] CH_UNDER    = 8'h5f;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_EQUAL    = 8'h3d;
  localparam logic [7:0] CH_SLASH    = 8'h2f;
  localparam logic [7:0] CH_STAR     = 8'h2a;
  localparam logic [7:0] CH_NEWLINE  = 8'h0a;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_ONE      = 8'h31;

  localparam logic [1:0] SUB_INT  = 2'd0;
  localparam logic [1:0] SUB_FRAC = 2'd1;
  localparam logic [1:0] SUB_BIN  = 2'd2;
  localparam logic [1:0] SUB_EXPD = 2'd3;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [NEST_BITS-1:0]   NEST_MAX = {NEST_BITS{1'b1}};

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_ZERO, M_NUM, M_EXP, M_PLUS, M_EQ, M_SLASH,
    M_STRING, M_LINE, M_BLOCK, M_BSTAR, M_NEST, M_NSLASH, M_NPLUS
  } mode_t;

  mode_t                    mode_r, mode_nxt;
  logic [1:0]               sub_r, sub_nxt;
  logic [7:0]               quote_r, quote_nxt;
  logic                     esc_r, esc_nxt;
  logic [NEST_BITS-1:0]     depth_r, depth_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     accept;
  push_t                    push_nxt;

  function automatic tok_t mk(logic [3:0] k, logic [7:0] op, logic [POSITION_BITS-1:0] s,
                              logic [LENGTH_BITS-1:0] l, logic [1:0] e);
    tok_t                     t;
    logic [POSITION_BITS+31:0] sw;
    logic [LENGTH_BITS+15:0]   lw;
    sw       = {32'b0, s};
    lw       = {16'b0, l};
    t.kind   = k;
    t.opch   = op;
    t.start  = sw[31:0];
    t.length = (lw > {{LENGTH_BITS{1'b0}}, 16'hffff}) ? 16'hffff : lw[15:0];
    t.err    = e;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return ch inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch inside {[8'h30:8'h39]};
  endfunction

  assign in_ready = space_ok;
  assign accept   = in_valid && space_ok;

  always_comb begin
    logic [7:0]             c;
    logic                   reproc;
    logic                   acc;
    logic                   a_v, d_v;
    tok_t                   a_t, d_t;
    logic [LENGTH_BITS-1:0] len_grow;
    logic [NEST_BITS-1:0]   dn;
    c         = in_char_byte;
    reproc    = 1'b0;
    acc       = 1'b0;
    a_v       = 1'b0;
    d_v       = 1'b0;
    a_t       = '0;
    d_t       = '0;
    dn        = '0;
    len_grow  = (len_r == LEN_MAX) ? len_r : len_r + LENGTH_BITS'(1);
    mode_nxt  = mode_r;
    sub_nxt   = sub_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    depth_nxt = depth_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    push_nxt  = '0;

    if (in_end_of_input) begin
      case (mode_r)
        M_IDENT: begin
          a_v = 1'b1;
          a_t = mk(KIND_IDENT, 8'h00, start_r, len_r, ERR_NONE);
        end
        M_ZERO, M_NUM: begin
          a_v = 1'b1;
          a_t = mk((sub_r == SUB_FRAC || sub_r == SUB_EXPD) ? KIND_DOUBLE : KIND_INT,
                   8'h00, start_r, len_r, ERR_NONE);
        end
        M_EXP: begin
          a_v = 1'b1;
          a_t = mk(KIND_ERROR, 8'h00, start_r, len_r, ERR_BAD_EXPONENT);
        end
        M_PLUS: begin
          a_v = 1'b1;
          a_t = mk(KIND_SINGLE_OP, CH_PLUS, start_r, LENGTH_BITS'(1), ERR_NONE);
        end
        M_EQ: begin
          a_v = 1'b1;
          a_t = mk(KIND_SINGLE_OP, CH_EQUAL, start_r, LENGTH_BITS'(1), ERR_NONE);
        end
        M_SLASH: begin
          a_v = 1'b1;
          a_t = mk(KIND_SINGLE_OP, CH_SLASH, start_r, LENGTH_BITS'(1), ERR_NONE);
        end
        M_STRING, M_BLOCK, M_BSTAR, M_NEST, M_NSLASH, M_NPLUS: begin
          a_v = 1'b1;
          a_t = mk(KIND_ERROR, 8'h00, start_r, len_r, ERR_UNTERMINATED);
        end
        default: ;
      endcase
      d_v       = 1'b1;
      d_t       = mk(KIND_END, 8'h00, pos_r, '0, ERR_NONE);
      mode_nxt  = M_IDLE;
      esc_nxt   = 1'b0;
      depth_nxt = '0;
      sub_nxt   = SUB_INT;
    end else begin
      case (mode_r)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            len_nxt = len_grow;
          end else begin
            a_v      = 1'b1;
            a_t      = mk(KIND_IDENT, 8'h00, start_r, len_r, ERR_NONE);
            mode_nxt = M_IDLE;
            reproc   = 1'b1;
          end
        end
        M_ZERO, M_NUM: begin
          if (mode_r == M_ZERO && (c == CH_LO_B || c == CH_UP_B)) begin
            mode_nxt = M_NUM;
            sub_nxt  = SUB_BIN;
            len_nxt  = len_grow;
          end else begin
            mode_nxt = M_NUM;
            case (sub_r)
              SUB_BIN:  acc = (c == CH_ZERO || c == CH_ONE || c == CH_UNDER);
              SUB_EXPD: acc = (is_digit(c) || c == CH_UNDER);
              default: begin
                if (is_digit(c) || c == CH_UNDER) begin
                  acc = 1'b1;
                end else if (c == CH_DOT && sub_r == SUB_INT) begin
                  sub_nxt = SUB_FRAC;
                  acc     = 1'b1;
                end else if (c == CH_LO_E || c == CH_UP_E) begin
                  sub_nxt  = SUB_FRAC;
                  mode_nxt = M_EXP;
                  acc      = 1'b1;
                end
              end
            endcase
            if (acc) begin
              len_nxt = len_grow;
            end else begin
              a_v      = 1'b1;
              a_t      = mk((sub_r == SUB_FRAC || sub_r == SUB_EXPD) ? KIND_DOUBLE : KIND_INT,
                            8'h00, start_r, len_r, ERR_NONE);
              mode_nxt = M_IDLE;
              reproc   = 1'b1;
            end
          end
        end
        M_EXP: begin
          if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin
            sub_nxt  = SUB_EXPD;
            mode_nxt = M_NUM;
            len_nxt  = len_grow;
          end else begin
            a_v      = 1'b1;
            a_t      = mk(KIND_ERROR, 8'h00, start_r, len_r, ERR_BAD_EXPONENT);
            mode_nxt = M_IDLE;
            reproc   = 1'b1;
          end
        end
        M_PLUS: begin
          mode_nxt = M_IDLE;
          a_v      = 1'b1;
          if (c == CH_PLUS) begin
            a_t = mk(KIND_PLUS_PLUS, 8'h00, start_r, LENGTH_BITS'(2), ERR_NONE);
          end else if (c == CH_EQUAL) begin
            a_t = mk(KIND_PLUS_EQ, 8'h00, start_r, LENGTH_BITS'(2), ERR_NONE);
          end else begin
            a_t    = mk(KIND_SINGLE_OP, CH_PLUS, start_r, LENGTH_BITS'(1), ERR_NONE);
            reproc = 1'b1;
          end
        end
        M_EQ: begin
          mode_nxt = M_IDLE;
          a_v      = 1'b1;
          if (c == CH_EQUAL) begin
            a_t = mk(KIND_EQ_EQ, 8'h00, start_r, LENGTH_BITS'(2), ERR_NONE);
          end else begin
            a_t    = mk(KIND_SINGLE_OP, CH_EQUAL, start_r, LENGTH_BITS'(1), ERR_NONE);
            reproc = 1'b1;
          end
        end
        M_SLASH: begin
          len_nxt = len_grow;
          if (c == CH_SLASH) begin
            mode_nxt = M_LINE;
          end else if (c == CH_STAR) begin
            mode_nxt = M_BLOCK;
          end else if (c == CH_PLUS) begin
            mode_nxt  = M_NEST;
            depth_nxt = NEST_BITS'(1);
          end else begin
            a_v      = 1'b1;
            a_t      = mk(KIND_SINGLE_OP, CH_SLASH, start_r, LENGTH_BITS'(1), ERR_NONE);
            mode_nxt = M_IDLE;
            reproc   = 1'b1;
          end
        end
        M_STRING: begin
          len_nxt = len_grow;
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (c == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (c == quote_r) begin
            a_v      = 1'b1;
            a_t      = mk(KIND_STRING, 8'h00, start_r, len_grow, ERR_NONE);
            mode_nxt = M_IDLE;
          end
        end
        M_LINE: begin
          if (c == CH_NEWLINE) mode_nxt = M_IDLE;
        end
        M_BLOCK, M_BSTAR: begin
          len_nxt = len_grow;
          if (mode_r == M_BSTAR && c == CH_SLASH) begin
            mode_nxt = M_IDLE;
          end else begin
            mode_nxt = (c == CH_STAR) ? M_BSTAR : M_BLOCK;
          end
        end
        M_NEST, M_NSLASH, M_NPLUS: begin
          len_nxt = len_grow;
          if (mode_r == M_NSLASH && c == CH_PLUS) begin
            if (depth_r != NEST_MAX) depth_nxt = depth_r + NEST_BITS'(1);
            mode_nxt = M_NEST;
          end else if (mode_r == M_NPLUS && c == CH_SLASH) begin
            dn        = (depth_r != '0) ? depth_r - NEST_BITS'(1) : depth_r;
            depth_nxt = dn;
            mode_nxt  = (dn == '0) ? M_IDLE : M_NEST;
          end else begin
            mode_nxt = (c == CH_SLASH) ? M_NSLASH : ((c == CH_PLUS) ? M_NPLUS : M_NEST);
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          reproc   = 1'b1;
        end
      endcase

      if (reproc) begin
        if (is_alpha(c) || c == CH_UNDER) begin
          mode_nxt  = M_IDENT;
          start_nxt = pos_r;
          len_nxt   = LENGTH_BITS'(1);
        end else if (is_digit(c)) begin
          sub_nxt   = SUB_INT;
          mode_nxt  = (c == CH_ZERO) ? M_ZERO : M_NUM;
          start_nxt = pos_r;
          len_nxt   = LENGTH_BITS'(1);
        end else if (c inside {CH_SPACE, CH_NEWLINE, CH_TAB, CH_CR}) begin
          mode_nxt = M_IDLE;
        end else if (c inside {CH_PLUS, CH_EQUAL, CH_SLASH}) begin
          mode_nxt  = (c == CH_PLUS) ? M_PLUS : ((c == CH_EQUAL) ? M_EQ : M_SLASH);
          start_nxt = pos_r;
          len_nxt   = LENGTH_BITS'(1);
        end else if (c inside {CH_DOT, 8'h2c, 8'h3b, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b,
                               8'h7d, 8'h3c, 8'h3e, CH_MINUS, CH_STAR}) begin
          d_v = 1'b1;
          d_t = mk(KIND_SINGLE_OP, c, pos_r, LENGTH_BITS'(1), ERR_NONE);
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          mode_nxt  = M_STRING;
          start_nxt = pos_r;
          len_nxt   = LENGTH_BITS'(1);
          quote_nxt = c;
          esc_nxt   = 1'b0;
        end else begin
          d_v = 1'b1;
          d_t = mk(KIND_ERROR, 8'h00, pos_r, LENGTH_BITS'(1), ERR_UNKNOWN_BYTE);
        end
      end
      pos_nxt = pos_r + POSITION_BITS'(1);
    end

    if (a_v && d_v) begin
      push_nxt.count       = 2'd2;
      push_nxt.first       = a_t;
      push_nxt.second      = d_t;
      push_nxt.second.last = 1'b1;
    end else if (a_v || d_v) begin
      push_nxt.count      = 2'd1;
      push_nxt.first      = a_v ? a_t : d_t;
      push_nxt.first.last = 1'b1;
    end
    if (!accept) push_nxt.count = 2'd0;
  end

  assign push = push_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      sub_r   <= SUB_INT;
      quote_r <= 8'h00;
      esc_r   <= 1'b0;
      depth_r <= '0;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      sub_r   <= sub_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      depth_r <= depth_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_queue.sv =====
// Back part of the tokenizer: a short token queue that takes up to two tokens per beat
// and hands one token per beat to the result channel. Depends on stt_pkg.
`default_nettype none

module stt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire stt_pkg::push_t push,
  output logic                space_ok,
  output logic                out_valid,
  input  wire logic           out_ready,
  output stt_pkg::tok_t       head
);
  import stt_pkg::*;

  tok_t              mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign head      = mem[rd_ptr_r];
  assign space_ok  = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QIDX_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + QIDX_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr_r] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr_r + QIDX_W'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/source_text_tokenizer.sv =====
// Source text tokenizer: byte-stream lexer with a scanner front and a token queue back.
// Depends on stt_pkg, stt_scanner and stt_queue.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one source byte per beat, or an
//   end-of-input marker (in_end_of_input high, in_char_byte ignored).
//   Result channel (out_valid/out_ready) carries one token per beat: kind,
//   operator byte, start offset, length, error code and a flag marking the last
//   token caused by one input beat. One input beat yields zero, one or two tokens.
//   A token is written into the token queue when the input beat that completes it
//   is accepted and is offered once the tokens ahead of it have drained. One input
//   beat is accepted per cycle while the four-entry token queue has room for two
//   tokens; the result side drains one token per cycle while out_ready is high.
//   When the receiver stalls, tokens wait in the queue and the input side keeps
//   accepting until fewer than two slots remain; then in_ready drops.
//   Reset (rst_n low, synchronous) returns the scanner to the idle state with the
//   byte position at zero and empties the queue.
`default_nettype none

module source_text_tokenizer #(
  parameter int NEST_BITS     = 8,
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_token_kind,
  output logic [7:0]       out_operator_char,
  output logic [31:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic [1:0]       out_error_code,
  output logic             out_last_in_run
);
  import stt_pkg::*;

  push_t push;
  tok_t  head;
  logic  space_ok;

  stt_scanner #(
    .NEST_BITS    (NEST_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_scanner (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_byte   (in_char_byte),
    .in_end_of_input(in_end_of_input),
    .space_ok       (space_ok),
    .push           (push)
  );

  stt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_token_kind    = head.kind;
  assign out_operator_char = head.opch;
  assign out_token_start   = head.start;
  assign out_token_length  = head.length;
  assign out_error_code    = head.err;
  assign out_last_in_run   = head.last;

endmodule

`default_nettype wire

// ===== hw/rtl/stt_checker.sv =====
// Port-level checks for the source text tokenizer result channel.
// Depends on stt_pkg; bound to source_text_tokenizer below.
`default_nettype none

module stt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_token_kind,
  input wire logic [7:0]  out_operator_char,
  input wire logic [15:0] out_token_length,
  input wire logic [1:0]  out_error_code,
  input wire logic        out_last_in_run
);
  import stt_pkg::*;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind)
      && $stable(out_token_length))
    else $error("stalled token changed");

  a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_ERROR |-> out_error_code == ERR_NONE)
    else $error("error code on non-error token");

  a_opch_only_on_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_SINGLE_OP |-> out_operator_char == 8'h00)
    else $error("operator byte on non-operator token");

  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_END |-> out_last_in_run && out_token_length == 16'd0)
    else $error("malformed end token");

  a_pair_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == KIND_PLUS_PLUS || out_token_kind == KIND_PLUS_EQ
      || out_token_kind == KIND_EQ_EQ) |-> out_token_length == 16'd2)
    else $error("operator pair length not two");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_token_kind   (out_token_kind),
  .out_operator_char(out_operator_char),
  .out_token_length (out_token_length),
  .out_error_code   (out_error_code),
  .out_last_in_run  (out_last_in_run)
);

`default_nettype wire

// ===== tb/sv/tb_source_text_tokenizer.sv =====
// Testbench for source_text_tokenizer: drives byte streams and end-of-text beats, predicts
// the token stream with a behavioral lexer and checks every result beat in order.
// Depends on stt_pkg and the source_text_tokenizer RTL.
module tb_source_text_tokenizer;
  import stt_pkg::*;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_ZERO, SCAN_NUM, SCAN_EXP, SCAN_PLUS, SCAN_EQ, SCAN_SLASH,
    SCAN_STRING, SCAN_LINE, SCAN_BLOCK, SCAN_BSTAR, SCAN_NEST, SCAN_NSLASH, SCAN_NPLUS
  } scan_t;

  localparam logic [1:0] SUB_INT  = 2'd0;
  localparam logic [1:0] SUB_FRAC = 2'd1;
  localparam logic [1:0] SUB_BIN  = 2'd2;
  localparam logic [1:0] SUB_EXP  = 2'd3;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_BSL = 8'h5C;

  localparam logic [7:0]  DEPTH_MAX = 8'hFF;
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;
  localparam int          HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [7:0]  out_operator_char;
  logic [31:0] out_token_start;
  logic [15:0] out_token_length;
  logic [1:0]  out_error_code;
  logic        out_last_in_run;

  source_text_tokenizer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_byte      (in_char_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_operator_char (out_operator_char),
    .out_token_start   (out_token_start),
    .out_token_length  (out_token_length),
    .out_error_code    (out_error_code),
    .out_last_in_run   (out_last_in_run)
  );

  always #1 clk = ~clk;

  src_item_t src_bytes[$];
  tok_t      tokens_due[$];
  int        n_src = 0;
  int        in_sent = 0;
  int        in_taken = 0;
  int        bad_tokens = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_asks = 0;
  int        holds_done = 0;
  int        hold_left = 0;

  // lexer state
  scan_t       lx_mode = SCAN_IDLE;
  logic [1:0]  lx_sub = SUB_INT;
  logic [7:0]  lx_quote = 8'h00;
  logic        lx_esc = 1'b0;
  logic [7:0]  lx_depth = 8'h00;
  logic [31:0] lx_start = 32'h0;
  logic [15:0] lx_len = 16'h0;
  logic [31:0] lx_pos = 32'h0;
  tok_t        held_tok;
  bit          have_held = 1'b0;

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_op(input logic [7:0] c);
    return c == "." || c == "," || c == ";" || c == "(" || c == ")" || c == "[" ||
           c == "]" || c == "{" || c == "}" || c == "<" || c == ">" || c == "-" || c == "*";
  endfunction

  function automatic void put_tok(input logic [3:0] kind, input logic [7:0] opch,
                                  input logic [31:0] start, input logic [15:0] len,
                                  input logic [1:0] err);
    if (have_held) tokens_due.push_back(held_tok);
    held_tok.kind   = kind;
    held_tok.opch   = opch;
    held_tok.start  = start;
    held_tok.length = len;
    held_tok.err    = err;
    held_tok.last   = 1'b0;
    have_held = 1'b1;
  endfunction

  function automatic void grow();
    if (lx_len != LEN_MAX) lx_len++;
  endfunction

  function automatic void go_idle();
    lx_mode = SCAN_IDLE;
  endfunction

  function automatic void open_lexeme(input scan_t m);
    lx_mode  = m;
    lx_start = lx_pos;
    lx_len   = 16'd1;
  endfunction

  function automatic void close_number();
    if (lx_sub == SUB_FRAC || lx_sub == SUB_EXP)
      put_tok(KIND_DOUBLE, 8'h00, lx_start, lx_len, ERR_NONE);
    else
      put_tok(KIND_INT, 8'h00, lx_start, lx_len, ERR_NONE);
    go_idle();
  endfunction

  function automatic void start_fresh(input logic [7:0] c);
    if (is_alpha(c) || c == "_") begin
      open_lexeme(SCAN_IDENT);
    end else if (is_digit(c)) begin
      lx_sub = SUB_INT;
      if (c == "0") open_lexeme(SCAN_ZERO);
      else open_lexeme(SCAN_NUM);
    end else if (c == "+") begin
      open_lexeme(SCAN_PLUS);
    end else if (c == "=") begin
      open_lexeme(SCAN_EQ);
    end else if (c == "/") begin
      open_lexeme(SCAN_SLASH);
    end else if (is_op(c)) begin
      put_tok(KIND_SINGLE_OP, c, lx_pos, 16'd1, ERR_NONE);
    end else if (c == CH_SQ || c == CH_DQ) begin
      open_lexeme(SCAN_STRING);
      lx_quote = c;
      lx_esc   = 1'b0;
    end else if (c != " " && c != CH_LF && c != CH_TAB && c != CH_CR) begin
      put_tok(KIND_ERROR, 8'h00, lx_pos, 16'd1, ERR_UNKNOWN_BYTE);
    end
  endfunction

  function automatic bit number_step(input logic [7:0] c);
    bit more;
    if (lx_sub == SUB_BIN) more = (c == "0" || c == "1" || c == "_");
    else more = is_digit(c) || c == "_";
    if (more) begin
      grow();
      return 1'b0;
    end
    if (lx_sub == SUB_INT || lx_sub == SUB_FRAC) begin
      if (c == "." && lx_sub == SUB_INT) begin
        lx_sub = SUB_FRAC;
        grow();
        return 1'b0;
      end
      if (c == "e" || c == "E") begin
        lx_sub  = SUB_FRAC;
        lx_mode = SCAN_EXP;
        grow();
        return 1'b0;
      end
    end
    close_number();
    return 1'b1;
  endfunction

  // Returns 1 when no token is open or the byte ends the open token, so the byte must be scanned afresh.
  function automatic bit continue_lexeme(input logic [7:0] c);
    case (lx_mode)
      SCAN_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          grow();
          return 1'b0;
        end
        put_tok(KIND_IDENT, 8'h00, lx_start, lx_len, ERR_NONE);
        go_idle();
        return 1'b1;
      end
      SCAN_ZERO: begin
        lx_mode = SCAN_NUM;
        if (c == "b" || c == "B") begin
          lx_sub = SUB_BIN;
          grow();
          return 1'b0;
        end
        return number_step(c);
      end
      SCAN_NUM: return number_step(c);
      SCAN_EXP: begin
        if (is_digit(c) || c == "+" || c == "-") begin
          lx_sub  = SUB_EXP;
          lx_mode = SCAN_NUM;
          grow();
          return 1'b0;
        end
        put_tok(KIND_ERROR, 8'h00, lx_start, lx_len, ERR_BAD_EXPONENT);
        go_idle();
        return 1'b1;
      end
      SCAN_PLUS: begin
        go_idle();
        if (c == "+") begin
          put_tok(KIND_PLUS_PLUS, 8'h00, lx_start, 16'd2, ERR_NONE);
          return 1'b0;
        end
        if (c == "=") begin
          put_tok(KIND_PLUS_EQ, 8'h00, lx_start, 16'd2, ERR_NONE);
          return 1'b0;
        end
        put_tok(KIND_SINGLE_OP, "+", lx_start, 16'd1, ERR_NONE);
        return 1'b1;
      end
      SCAN_EQ: begin
        go_idle();
        if (c == "=") begin
          put_tok(KIND_EQ_EQ, 8'h00, lx_start, 16'd2, ERR_NONE);
          return 1'b0;
        end
        put_tok(KIND_SINGLE_OP, "=", lx_start, 16'd1, ERR_NONE);
        return 1'b1;
      end
      SCAN_SLASH: begin
        grow();
        if (c == "/") begin
          lx_mode = SCAN_LINE;
          return 1'b0;
        end
        if (c == "*") begin
          lx_mode = SCAN_BLOCK;
          return 1'b0;
        end
        if (c == "+") begin
          lx_mode  = SCAN_NEST;
          lx_depth = 8'd1;
          return 1'b0;
        end
        put_tok(KIND_SINGLE_OP, "/", lx_start, 16'd1, ERR_NONE);
        go_idle();
        return 1'b1;
      end
      SCAN_STRING: begin
        grow();
        if (lx_esc) begin
          lx_esc = 1'b0;
          return 1'b0;
        end
        if (c == CH_BSL) begin
          lx_esc = 1'b1;
          return 1'b0;
        end
        if (c == lx_quote) begin
          put_tok(KIND_STRING, 8'h00, lx_start, lx_len, ERR_NONE);
          go_idle();
        end
        return 1'b0;
      end
      SCAN_LINE: begin
        if (c == CH_LF) go_idle();
        return 1'b0;
      end
      SCAN_BLOCK, SCAN_BSTAR: begin
        grow();
        if (lx_mode == SCAN_BSTAR && c == "/") begin
          go_idle();
          return 1'b0;
        end
        lx_mode = (c == "*") ? SCAN_BSTAR : SCAN_BLOCK;
        return 1'b0;
      end
      SCAN_NEST, SCAN_NSLASH, SCAN_NPLUS: begin
        grow();
        if (lx_mode == SCAN_NSLASH && c == "+") begin
          if (lx_depth != DEPTH_MAX) lx_depth++;
          lx_mode = SCAN_NEST;
          return 1'b0;
        end
        if (lx_mode == SCAN_NPLUS && c == "/") begin
          if (lx_depth != 8'd0) lx_depth--;
          if (lx_depth == 8'd0) go_idle();
          else lx_mode = SCAN_NEST;
          return 1'b0;
        end
        if (c == "/") lx_mode = SCAN_NSLASH;
        else if (c == "+") lx_mode = SCAN_NPLUS;
        else lx_mode = SCAN_NEST;
        return 1'b0;
      end
      default: begin
        go_idle();
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void close_open_lexeme();
    case (lx_mode)
      SCAN_IDENT: put_tok(KIND_IDENT, 8'h00, lx_start, lx_len, ERR_NONE);
      SCAN_ZERO, SCAN_NUM: close_number();
      SCAN_EXP: put_tok(KIND_ERROR, 8'h00, lx_start, lx_len, ERR_BAD_EXPONENT);
      SCAN_PLUS: put_tok(KIND_SINGLE_OP, "+", lx_start, 16'd1, ERR_NONE);
      SCAN_EQ: put_tok(KIND_SINGLE_OP, "=", lx_start, 16'd1, ERR_NONE);
      SCAN_SLASH: put_tok(KIND_SINGLE_OP, "/", lx_start, 16'd1, ERR_NONE);
      SCAN_STRING, SCAN_BLOCK, SCAN_BSTAR, SCAN_NEST, SCAN_NSLASH, SCAN_NPLUS:
        put_tok(KIND_ERROR, 8'h00, lx_start, lx_len, ERR_UNTERMINATED);
      default: begin
      end
    endcase
  endfunction

  function automatic void tokenize_beat(input logic [7:0] c, input logic eoi);
    have_held = 1'b0;
    if (eoi) begin
      close_open_lexeme();
      put_tok(KIND_END, 8'h00, lx_pos, 16'd0, ERR_NONE);
      go_idle();
      lx_esc   = 1'b0;
      lx_depth = 8'd0;
      lx_sub   = SUB_INT;
    end else begin
      if (continue_lexeme(c)) start_fresh(c);
      lx_pos++;
    end
    if (have_held) begin
      held_tok.last = 1'b1;
      tokens_due.push_back(held_tok);
    end
  endfunction

  function automatic void put_ch(input logic [7:0] c);
    src_item_t it;
    it.ch  = c;
    it.eoi = 1'b0;
    src_bytes.push_back(it);
    n_src++;
  endfunction

  function automatic void put_eoi();
    src_item_t it;
    it.ch  = 8'($urandom_range(255));
    it.eoi = 1'b1;
    src_bytes.push_back(it);
    n_src++;
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    if (r < 26) return "a" + 8'(r);
    return "A" + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_word_ch();
    int r;
    r = $urandom_range(63);
    if (r < 52) return rand_letter();
    if (r < 62) return rand_digit();
    return "_";
  endfunction

  function automatic logic [7:0] rand_filler(input logic [7:0] skip_a, input logic [7:0] skip_b);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == skip_a || c == skip_b) c = "q";
    return c;
  endfunction

  function automatic void put_digits(input int n);
    put_ch(rand_digit());
    repeat (n) begin
      if ($urandom_range(5) == 0) put_ch("_");
      else put_ch(rand_digit());
    end
  endfunction

  function automatic void put_space();
    case ($urandom_range(3))
      0: put_ch(" ");
      1: put_ch(CH_TAB);
      2: put_ch(CH_CR);
      default: put_ch(CH_LF);
    endcase
  endfunction

  // Emit one lexeme with random content, well-formed or malformed, an end-of-input beat, or a piece of noise.
  function automatic void gen_lexeme();
    string      ops = ".,;()[]{}<>-*";
    logic [7:0] q;
    int         n;
    case ($urandom_range(19))
      0, 1, 2: begin
        if ($urandom_range(3) == 0) put_ch("_");
        else put_ch(rand_letter());
        repeat ($urandom_range(6)) put_ch(rand_word_ch());
      end
      3: put_digits($urandom_range(5));
      4: begin
        put_ch("0");
        if ($urandom_range(1) == 0) put_ch("b");
        else put_ch("B");
        repeat ($urandom_range(8)) begin
          n = $urandom_range(4);
          if (n == 0) put_ch("_");
          else if (n < 3) put_ch("0");
          else put_ch("1");
        end
      end
      5: begin
        put_digits($urandom_range(3));
        put_ch(".");
        if ($urandom_range(3) != 0) put_digits($urandom_range(3));
      end
      6: begin
        put_digits($urandom_range(2));
        if ($urandom_range(2) == 0) begin
          put_ch(".");
          put_digits($urandom_range(2));
        end
        if ($urandom_range(1) == 0) put_ch("e");
        else put_ch("E");
        case ($urandom_range(3))
          0: begin
            if ($urandom_range(1) == 0) put_ch("+");
            else put_ch("-");
            put_digits($urandom_range(2));
          end
          1: put_digits($urandom_range(2));
          2: put_ch(rand_letter());
          default: begin
          end
        endcase
      end
      7, 8: begin
        q = ($urandom_range(1) == 0) ? CH_SQ : CH_DQ;
        put_ch(q);
        repeat ($urandom_range(6)) begin
          if ($urandom_range(4) == 0) begin
            put_ch(CH_BSL);
            put_ch(8'($urandom_range(255)));
          end else begin
            put_ch(rand_filler(q, CH_BSL));
          end
        end
        if ($urandom_range(7) == 0) put_eoi();
        else put_ch(q);
      end
      9, 10: put_ch(ops[$urandom_range(ops.len() - 1)]);
      11: begin
        case ($urandom_range(5))
          0: put_str("++");
          1: put_str("+=");
          2: put_str("==");
          3: put_ch("+");
          4: put_ch("=");
          default: put_ch("/");
        endcase
      end
      12: begin
        put_str("//");
        repeat ($urandom_range(8)) put_ch(rand_filler(CH_LF, CH_LF));
        if ($urandom_range(7) == 0) put_eoi();
        else put_ch(CH_LF);
      end
      13: begin
        put_str("/*");
        repeat ($urandom_range(10)) begin
          if ($urandom_range(5) == 0) put_ch("*");
          else put_ch(rand_filler("*", "/"));
        end
        if ($urandom_range(7) == 0) put_eoi();
        else put_str("*/");
      end
      14: begin
        n = 1 + $urandom_range(2);
        repeat (n) begin
          put_str("/+");
          repeat ($urandom_range(4)) put_ch(rand_filler("/", "+"));
        end
        repeat (n) begin
          repeat ($urandom_range(3)) put_ch(rand_filler("/", "+"));
          put_str("+/");
        end
        if ($urandom_range(7) == 0) put_eoi();
      end
      15, 16: repeat (1 + $urandom_range(2)) put_space();
      17: put_ch(8'($urandom_range(255)));
      18: put_eoi();
      default: begin
        case ($urandom_range(4))
          0: put_str("1e");
          1: put_str("'ab");
          2: put_str("/*x*");
          3: put_str("/+/+x+/");
          default: put_ch("+");
        endcase
        put_eoi();
      end
    endcase
  endfunction

  function automatic void log_bad(input string what, input tok_t want, input tok_t got);
    bad_tokens++;
    if (bad_tokens <= 10) begin
      $display("%s: want kind=%0d op=%02h start=%0d len=%0d err=%0d last=%0b",
               what, want.kind, want.opch, want.start, want.length, want.err, want.last);
      $display("  got kind=%0d op=%02h start=%0d len=%0d err=%0d last=%0b",
               got.kind, got.opch, got.start, got.length, got.err, got.last);
    end
  endfunction

  always @(negedge clk) begin
    src_item_t it;
    if (rst_n && (!in_valid || in_taken == in_sent)) begin
      if (src_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = src_bytes.pop_front();
        in_valid        <= 1'b1;
        in_char_byte    <= it.ch;
        in_end_of_input <= it.eoi;
        in_sent         <= in_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (holds_done != hold_asks) begin
      holds_done = hold_asks;
      hold_left  = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tokenize_beat(in_char_byte, in_end_of_input);
        in_taken <= in_taken + 1;
      end
      if (out_valid && out_ready) begin
        got.kind   = out_token_kind;
        got.opch   = out_operator_char;
        got.start  = out_token_start;
        got.length = out_token_length;
        got.err    = out_error_code;
        got.last   = out_last_in_run;
        if (tokens_due.size() == 0) begin
          log_bad("unexpected token", '0, got);
        end else begin
          want = tokens_due.pop_front();
          if (got !== want) log_bad("token mismatch", want, got);
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (src_bytes.size() != 0 || in_taken != in_sent || tokens_due.size() != 0);
  endtask

  task automatic run_phase(input int snd_idle, input int rcv_stall, input int beats,
                           input bit hold);
    int base;
    send_idle_pct  = snd_idle;
    recv_stall_pct = rcv_stall;
    base = n_src;
    while (n_src - base < beats) begin
      gen_lexeme();
      if ($urandom_range(2) == 0) put_ch(" ");
    end
    put_eoi();
    if (hold) hold_asks++;
    wait_drained();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    put_ch(8'h00);
    put_ch(8'hFF);
    put_ch(8'h80);
    put_str("x_9 ");
    put_str("+ /");
    put_str("=1e;");
    put_str("0b1+==");
    put_ch(CH_DQ);
    put_ch("a");
    put_eoi();
    put_eoi();
    wait_drained();

    run_phase(10, 71, 100, 1'b0);
    run_phase(71, 10, 100, 1'b0);
    run_phase(0, 0, 100, 1'b1);

    // saturate the nesting depth, unwind a few levels, leave it open
    put_str(" /+");
    repeat (259) put_str("/+");
    repeat (5) put_str("+/");
    put_eoi();
    wait_drained();

    repeat (20) @(negedge clk);
    bad_tokens += tokens_due.size();
    if (bad_tokens == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
